FILE: design/hdse_pkg.sv
// shared types, codes and byte constants of the html delimiter scan engine
package hdse_pkg;

   localparam int LANES_DEFAULT       = 8;
   localparam int OFFSET_BITS_DEFAULT = 31;

   localparam int MODE_W = 4;
   localparam int BASE_W = 31;
   localparam int POS_W  = 32;

   // scan modes
   localparam logic [MODE_W-1:0] MODE_TEXT     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_TAGNAME  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_DQ_AMP   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_SQ_AMP   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_DQ       = 4'd4;
   localparam logic [MODE_W-1:0] MODE_SQ       = 4'd5;
   localparam logic [MODE_W-1:0] MODE_ATTRS    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_UNQUOTED = 4'd7;
   localparam logic [MODE_W-1:0] MODE_GT       = 4'd8;
   localparam logic [MODE_W-1:0] MODE_ASCII    = 4'd9;

   // quote tracking in attrs mode
   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
   localparam logic [1:0] QUOTE_SINGLE = 2'd2;

   // delimiter bytes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_HIGH  = 8'h80;

   typedef struct packed {
      logic [1:0] quote;
      logic       slash;
   } attr_state_type;

   typedef struct packed {
      logic hit;
      logic adj;
      logic self_close;
   } lane_out_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
      logic             self_close;
      logic             all_ascii;
   } rsp_data_type;

endpackage

FILE: design/hdse_if.sv
// request and response channel interfaces of the scan engine
interface hdse_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_bytes;
   logic [3:0]  byte_count;
   logic        first_item;
   logic        last_item;
   logic [30:0] base_offset;

   modport source (output valid, data_bytes, byte_count, first_item, last_item, base_offset,
                   input ready);
   modport sink (input valid, data_bytes, byte_count, first_item, last_item, base_offset,
                 output ready);
endinterface

interface hdse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] position;
   logic        found;
   logic        self_close;
   logic        all_ascii;

   modport source (output valid, position, found, self_close, all_ascii, input ready);
   modport sink (input valid, position, found, self_close, all_ascii, output ready);
endinterface

FILE: design/hdse_lane.sv
// one byte lane: delimiter test for the current mode and attrs quote/slash tracking
module hdse_lane (
   input  logic                          lane_valid,
   input  logic [hdse_pkg::MODE_W-1:0]   mode,
   input  logic [7:0]                    data_byte,
   input  hdse_pkg::attr_state_type      state_in,
   output hdse_pkg::attr_state_type      state_out,
   output hdse_pkg::lane_out_type        lane_out
);

   logic name_byte;

   always_comb begin
      name_byte = data_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                    8'h2D, 8'h5F, 8'h3A, 8'h2E, 8'h3C};
   end

   always_comb begin
      state_out = state_in;
      lane_out  = '0;
      if (lane_valid) begin
         case (mode)
            hdse_pkg::MODE_TEXT: begin
               lane_out.hit = data_byte inside {hdse_pkg::CH_LT, hdse_pkg::CH_AMP,
                                                hdse_pkg::CH_NUL, hdse_pkg::CH_CR};
            end
            hdse_pkg::MODE_TAGNAME: begin
               lane_out.hit = !name_byte;
            end
            hdse_pkg::MODE_DQ_AMP: begin
               lane_out.hit = data_byte inside {hdse_pkg::CH_DQ, hdse_pkg::CH_AMP};
            end
            hdse_pkg::MODE_SQ_AMP: begin
               lane_out.hit = data_byte inside {hdse_pkg::CH_SQ, hdse_pkg::CH_AMP};
            end
            hdse_pkg::MODE_DQ: begin
               lane_out.hit = data_byte == hdse_pkg::CH_DQ;
            end
            hdse_pkg::MODE_SQ: begin
               lane_out.hit = data_byte == hdse_pkg::CH_SQ;
            end
            hdse_pkg::MODE_ATTRS: begin
               if (state_in.quote == hdse_pkg::QUOTE_DOUBLE) begin
                  if (data_byte == hdse_pkg::CH_DQ) state_out.quote = hdse_pkg::QUOTE_NONE;
               end else if (state_in.quote == hdse_pkg::QUOTE_SINGLE) begin
                  if (data_byte == hdse_pkg::CH_SQ) state_out.quote = hdse_pkg::QUOTE_NONE;
               end else if (data_byte == hdse_pkg::CH_GT) begin
                  lane_out.hit        = 1'b1;
                  lane_out.adj        = 1'b1;
                  lane_out.self_close = state_in.slash;
                  state_out.slash     = 1'b0;
               end else begin
                  state_out.slash = data_byte == hdse_pkg::CH_SLASH;
                  if (data_byte == hdse_pkg::CH_DQ) state_out.quote = hdse_pkg::QUOTE_DOUBLE;
                  else if (data_byte == hdse_pkg::CH_SQ) state_out.quote = hdse_pkg::QUOTE_SINGLE;
                  else state_out.quote = hdse_pkg::QUOTE_NONE;
               end
            end
            hdse_pkg::MODE_UNQUOTED: begin
               lane_out.hit = data_byte inside {hdse_pkg::CH_GT, hdse_pkg::CH_AMP,
                                                hdse_pkg::CH_SPACE, hdse_pkg::CH_TAB,
                                                hdse_pkg::CH_LF, hdse_pkg::CH_CR,
                                                hdse_pkg::CH_FF};
            end
            hdse_pkg::MODE_GT: begin
               lane_out.hit = data_byte == hdse_pkg::CH_GT;
               lane_out.adj = 1'b1;
            end
            hdse_pkg::MODE_ASCII: begin
               lane_out.hit = data_byte >= hdse_pkg::CH_HIGH;
            end
            default: begin
               lane_out = '0;
            end
         endcase
      end
   end

endmodule

FILE: design/hdse_merge.sv
// merge stage: picks the earliest lane hit and forms the result and next cursor
module hdse_merge #(
   parameter int LANES = hdse_pkg::LANES_DEFAULT,
   parameter int CUR_W = hdse_pkg::OFFSET_BITS_DEFAULT + 1
) (
   input  hdse_pkg::lane_out_type            lane_out [LANES],
   input  logic [CUR_W-1:0]                  start_cursor,
   input  logic [$clog2(LANES+1)-1:0]        lane_count,
   input  logic [hdse_pkg::MODE_W-1:0]       mode,
   input  logic                              last_item,
   input  logic                              ascii_so_far,
   output logic                              hit_any,
   output logic [CUR_W-1:0]                  next_cursor,
   output hdse_pkg::rsp_data_type            result
);

   localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

   logic [IDX_W-1:0] hit_idx;
   logic             hit_adj;
   logic             hit_sc;
   logic [CUR_W-1:0] pos_cur;
   logic [63:0]      pos_wide;

   // lowest lane wins
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      hit_adj = 1'b0;
      hit_sc  = 1'b0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (lane_out[i].hit) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
            hit_adj = lane_out[i].adj;
            hit_sc  = lane_out[i].self_close;
         end
      end
   end

   assign next_cursor = start_cursor + CUR_W'(lane_count);

   always_comb begin
      if (hit_any) begin
         pos_cur = start_cursor + CUR_W'(hit_idx) + CUR_W'(hit_adj);
      end else if (mode == hdse_pkg::MODE_ATTRS) begin
         // no closing > before range end: end plus one
         pos_cur = next_cursor + CUR_W'(1);
      end else begin
         pos_cur = next_cursor;
      end
      pos_wide          = 64'(pos_cur);
      result.position   = pos_wide[hdse_pkg::POS_W-1:0];
      result.found      = hit_any;
      result.self_close = hit_any && hit_sc;
      result.all_ascii  = !hit_any && last_item && (mode == hdse_pkg::MODE_ASCII) &&
                          ascii_so_far;
   end

endmodule

FILE: design/html_delimiter_scan_engine.sv
// top level of the html delimiter scan engine: scan state, lanes, merge and output skid
//
// The engine takes one request transfer per clock: up to LANES bytes are tested in parallel
// lanes for the delimiter of the mode in the scan_mode register, and the earliest match wins.
// A request yields a response when it holds the first match of the scan or ends the range
// (last_item) without one; other requests yield nothing, and bytes after a match are ignored
// until the next first_item. Scan state (cursor, quote, slash, ascii) is updated in the same
// cycle, so requests may follow back to back. Attrs mode carries its quote and slash state
// through the lanes in byte order within that cycle. Responses leave through an output
// register backed by a one-entry skid buffer; req ready drops only while both hold a
// response. Write scan_mode only while the engine is idle.
module html_delimiter_scan_engine #(
   parameter int LANES       = hdse_pkg::LANES_DEFAULT,
   parameter int OFFSET_BITS = hdse_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [hdse_pkg::MODE_W-1:0] csr_wr_data,
   hdse_req_if.sink                    req,
   hdse_rsp_if.source                  rsp
);

   localparam int CUR_W = OFFSET_BITS + 1;
   localparam int CNT_W = $clog2(LANES+1);

   logic [hdse_pkg::MODE_W-1:0] mode_ff;
   logic [CUR_W-1:0]            cursor_ff, cursor_in;
   logic                        done_ff, done_in;
   hdse_pkg::attr_state_type    attr_ff, attr_in;
   logic                        ascii_ff, ascii_in;

   logic                        accept;
   logic                        active;
   logic [CUR_W-1:0]            start_cursor;
   hdse_pkg::attr_state_type    start_attr;
   logic                        start_ascii;
   logic [CNT_W-1:0]            lane_count;
   hdse_pkg::attr_state_type    chain [LANES+1];
   hdse_pkg::lane_out_type      lane_out [LANES];
   logic                        hit_any;
   logic [CUR_W-1:0]            next_cursor;
   hdse_pkg::rsp_data_type      result;
   logic                        push;

   logic                        out_valid_ff, out_valid_in;
   hdse_pkg::rsp_data_type      out_data_ff, out_data_in;
   logic                        skid_valid_ff, skid_valid_in;
   hdse_pkg::rsp_data_type      skid_data_ff, skid_data_in;

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hdse_pkg::MODE_TEXT;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // a first_item clears the scan state before its bytes are tested
   assign active       = req.first_item || !done_ff;
   assign start_cursor = req.first_item ? CUR_W'(req.base_offset) : cursor_ff;
   assign start_attr   = req.first_item ? '0 : attr_ff;
   assign start_ascii  = req.first_item || ascii_ff;
   assign lane_count   = (req.byte_count > 4'(LANES)) ? CNT_W'(LANES)
                                                      : CNT_W'(req.byte_count);

   assign chain[0] = start_attr;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      hdse_lane u_lane (
         .lane_valid (active && (CNT_W'(i) < lane_count)),
         .mode       (mode_ff),
         .data_byte  (req.data_bytes[8*i +: 8]),
         .state_in   (chain[i]),
         .state_out  (chain[i+1]),
         .lane_out   (lane_out[i])
      );
   end

   hdse_merge #(
      .LANES (LANES),
      .CUR_W (CUR_W)
   ) u_merge (
      .lane_out     (lane_out),
      .start_cursor (start_cursor),
      .lane_count   (lane_count),
      .mode         (mode_ff),
      .last_item    (req.last_item),
      .ascii_so_far (start_ascii),
      .hit_any      (hit_any),
      .next_cursor  (next_cursor),
      .result       (result)
   );

   assign push = accept && active && (hit_any || req.last_item);

   always_comb begin
      cursor_in = cursor_ff;
      done_in   = done_ff;
      attr_in   = attr_ff;
      ascii_in  = ascii_ff;
      if (accept && active) begin
         attr_in  = chain[LANES];
         ascii_in = start_ascii && !(hit_any && mode_ff == hdse_pkg::MODE_ASCII);
         if (hit_any) begin
            cursor_in = start_cursor;
            done_in   = 1'b1;
         end else begin
            cursor_in = next_cursor;
            done_in   = req.last_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         done_ff   <= 1'b1;
         attr_ff   <= '0;
         ascii_ff  <= 1'b1;
      end else begin
         cursor_ff <= cursor_in;
         done_ff   <= done_in;
         attr_ff   <= attr_in;
         ascii_ff  <= ascii_in;
      end
   end

   // output register with one-entry skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp.ready) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : result;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.position   = out_data_ff.position;
   assign rsp.found      = out_data_ff.found;
   assign rsp.self_close = out_data_ff.self_close;
   assign rsp.all_ascii  = out_data_ff.all_ascii;

endmodule

FILE: design/hdse_checker.sv
// port-level checker of the scan engine and its bind
module hdse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_position,
   input logic        rsp_found,
   input logic        rsp_self_close,
   input logic        rsp_all_ascii
);

   // request side stalls only when a response is already waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !$past(rsp_ready))
      else $error("req stalled without a pending response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) && $stable(rsp_found)
                                  && $stable(rsp_self_close) && $stable(rsp_all_ascii))
      else $error("stalled response changed");

   a_self_close_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_self_close |-> rsp_found)
      else $error("self close without a match");

   a_ascii_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_ascii |-> !rsp_found && !rsp_self_close)
      else $error("all ascii together with a match");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("response pending after reset");

endmodule

bind html_delimiter_scan_engine hdse_checker u_hdse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_position   (rsp.position),
   .rsp_found      (rsp.found),
   .rsp_self_close (rsp.self_close),
   .rsp_all_ascii  (rsp.all_ascii)
);

FILE: test/html_delimiter_scan_engine_tb.sv
// self-checking testbench of the html delimiter scan engine
module html_delimiter_scan_engine_tb;

   localparam int LANES = hdse_pkg::LANES_DEFAULT;
   localparam logic [hdse_pkg::MODE_W-1:0] MODE_UNUSED_TOP = 4'd15;
   localparam logic [hdse_pkg::BASE_W-1:0] BASE_MAX        = 31'h7FFF_FFFF;
   localparam int                ITEM_TARGET     = 1050;
   localparam int                HOLD_OFF_CYCLES = 300;
   localparam int                SETTLE_CYCLES   = 8;
   localparam int                WATCHDOG_LIMIT  = 5000;

   localparam logic [7:0] SPECIAL_BYTES [14] = '{hdse_pkg::CH_LT, hdse_pkg::CH_AMP,
      hdse_pkg::CH_NUL, hdse_pkg::CH_CR, hdse_pkg::CH_DQ, hdse_pkg::CH_SQ, hdse_pkg::CH_GT,
      hdse_pkg::CH_SLASH, hdse_pkg::CH_SPACE, hdse_pkg::CH_TAB, hdse_pkg::CH_LF,
      hdse_pkg::CH_FF, hdse_pkg::CH_HIGH, 8'hFF};

   typedef struct packed {
      logic [63:0]                 data;
      logic [3:0]                  count;
      logic                        first;
      logic                        last;
      logic [hdse_pkg::BASE_W-1:0] base;
   } scan_chunk_type;

   // tracks the scan state of the engine and the responses it still owes
   class scan_result_tracker;
      logic [hdse_pkg::MODE_W-1:0] mode;
      logic [hdse_pkg::POS_W-1:0]  cursor;
      logic                        done;
      logic [1:0]                  quote;
      logic                        slash;
      logic                        ascii_ok;
      hdse_pkg::rsp_data_type      pending_results[$];
      int                          error_count;

      function new();
         mode        = hdse_pkg::MODE_TEXT;
         cursor      = '0;
         done        = 1'b1;
         quote       = hdse_pkg::QUOTE_NONE;
         slash       = 1'b0;
         ascii_ok    = 1'b1;
         error_count = 0;
      endfunction

      function void set_mode(logic [hdse_pkg::MODE_W-1:0] m);
         mode = m;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // a-z, A-Z, 0-9, '-', '_', ':', '.', '<'
      function bit is_name_byte(logic [7:0] b);
         return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
                (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
                b == 8'h3A || b == 8'h2E || b == hdse_pkg::CH_LT;
      endfunction

      function bit delimiter_hit(logic [7:0] b, output logic adj, output logic sc);
         adj = 1'b0;
         sc  = 1'b0;
         case (mode)
            hdse_pkg::MODE_TEXT:
               return b == hdse_pkg::CH_LT || b == hdse_pkg::CH_AMP ||
                      b == hdse_pkg::CH_NUL || b == hdse_pkg::CH_CR;
            hdse_pkg::MODE_TAGNAME: return !is_name_byte(b);
            hdse_pkg::MODE_DQ_AMP:  return b == hdse_pkg::CH_DQ || b == hdse_pkg::CH_AMP;
            hdse_pkg::MODE_SQ_AMP:  return b == hdse_pkg::CH_SQ || b == hdse_pkg::CH_AMP;
            hdse_pkg::MODE_DQ:      return b == hdse_pkg::CH_DQ;
            hdse_pkg::MODE_SQ:      return b == hdse_pkg::CH_SQ;
            hdse_pkg::MODE_ATTRS: begin
               if (quote == hdse_pkg::QUOTE_DOUBLE) begin
                  if (b == hdse_pkg::CH_DQ) quote = hdse_pkg::QUOTE_NONE;
                  return 1'b0;
               end
               if (quote == hdse_pkg::QUOTE_SINGLE) begin
                  if (b == hdse_pkg::CH_SQ) quote = hdse_pkg::QUOTE_NONE;
                  return 1'b0;
               end
               if (b == hdse_pkg::CH_GT) begin
                  adj   = 1'b1;
                  sc    = slash;
                  slash = 1'b0;
                  return 1'b1;
               end
               slash = (b == hdse_pkg::CH_SLASH);
               if (b == hdse_pkg::CH_DQ) quote = hdse_pkg::QUOTE_DOUBLE;
               else if (b == hdse_pkg::CH_SQ) quote = hdse_pkg::QUOTE_SINGLE;
               else quote = hdse_pkg::QUOTE_NONE;
               return 1'b0;
            end
            hdse_pkg::MODE_UNQUOTED:
               return b == hdse_pkg::CH_GT || b == hdse_pkg::CH_AMP ||
                      b == hdse_pkg::CH_SPACE || b == hdse_pkg::CH_TAB ||
                      b == hdse_pkg::CH_LF || b == hdse_pkg::CH_CR || b == hdse_pkg::CH_FF;
            hdse_pkg::MODE_GT: begin
               adj = 1'b1;
               return b == hdse_pkg::CH_GT;
            end
            hdse_pkg::MODE_ASCII: begin
               if (b >= hdse_pkg::CH_HIGH) begin
                  ascii_ok = 1'b0;
                  return 1'b1;
               end
               return 1'b0;
            end
            default: return 1'b0;
         endcase
      endfunction

      // returns 1 when the transfer belongs to an active scan
      function bit note_request(scan_chunk_type c);
         hdse_pkg::rsp_data_type r;
         int                     n;
         int                     i;
         logic                   adj;
         logic                   sc;
         if (c.first) begin
            cursor   = {1'b0, c.base};
            done     = 1'b0;
            quote    = hdse_pkg::QUOTE_NONE;
            slash    = 1'b0;
            ascii_ok = 1'b1;
         end
         if (done) return 1'b0;
         n = (c.count > LANES) ? LANES : int'(c.count);
         for (i = 0; i < n; i++) begin
            if (delimiter_hit(c.data[8*i +: 8], adj, sc)) begin
               done         = 1'b1;
               r.position   = cursor + hdse_pkg::POS_W'(adj);
               r.found      = 1'b1;
               r.self_close = sc;
               r.all_ascii  = 1'b0;
               pending_results.push_back(r);
               return 1'b1;
            end
            cursor = cursor + 1;
         end
         if (c.last) begin
            done         = 1'b1;
            r.position   = (mode == hdse_pkg::MODE_ATTRS) ? cursor + 1 : cursor;
            r.found      = 1'b0;
            r.self_close = 1'b0;
            r.all_ascii  = (mode == hdse_pkg::MODE_ASCII) && ascii_ok;
            pending_results.push_back(r);
         end
         return 1'b1;
      endfunction

      function void check_response(hdse_pkg::rsp_data_type got);
         hdse_pkg::rsp_data_type want;
         if (pending_results.size() == 0) begin
            $error("response with nothing expected: position %h", got.position);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.position !== want.position) begin
            $error("position: expected %h, actual %h", want.position, got.position);
            error_count++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %b, actual %b", want.found, got.found);
            error_count++;
         end
         if (got.self_close !== want.self_close) begin
            $error("self_close: expected %b, actual %b", want.self_close, got.self_close);
            error_count++;
         end
         if (got.all_ascii !== want.all_ascii) begin
            $error("all_ascii: expected %b, actual %b", want.all_ascii, got.all_ascii);
            error_count++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [hdse_pkg::MODE_W-1:0] csr_wr_data;

   hdse_req_if req_ch ();
   hdse_rsp_if rsp_ch ();

   html_delimiter_scan_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   scan_result_tracker tracker;
   int                 work_items;
   int                 burst_left;
   bit                 bursty;
   bit                 hold_off_request;
   bit                 hold_active;
   int                 stall_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] pack_text(string s);
      logic [63:0] v;
      int          i;
      v = '0;
      for (i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic scan_chunk_type make_chunk(logic [63:0] d, logic [3:0] n, logic f,
                                                 logic l, logic [hdse_pkg::BASE_W-1:0] base);
      scan_chunk_type c;
      c.data  = d;
      c.count = n;
      c.first = f;
      c.last  = l;
      c.base  = base;
      return c;
   endfunction

   task automatic push_chunk(scan_chunk_type c);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.data_bytes  <= c.data;
      req_ch.byte_count  <= c.count;
      req_ch.first_item  <= c.first;
      req_ch.last_item   <= c.last;
      req_ch.base_offset <= c.base;
      do @(posedge clock); while (!req_ch.ready);
      if (tracker.note_request(c)) work_items++;
      gap = 0;
      if (bursty) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mode changes only once the engine has drained
   task automatic write_mode(logic [hdse_pkg::MODE_W-1:0] m);
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      tracker.set_mode(m);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_scan();
      int             kind;
      int             len;
      int             k;
      int             b;
      int             r;
      scan_chunk_type c;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // stray transfer, mostly outside any scan
         c.data  = {$urandom, $urandom};
         c.count = 4'($urandom_range(0, 15));
         c.first = 1'b0;
         c.last  = 1'($urandom_range(0, 1));
         c.base  = hdse_pkg::BASE_W'($urandom);
         push_chunk(c);
         return;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
      for (k = 0; k < len; k++) begin
         for (b = 0; b < 8; b++) begin
            r = $urandom_range(0, 99);
            if (r < 4) c.data[8*b +: 8] = 8'($urandom_range(0, 255));
            else if (r < 10) c.data[8*b +: 8] = SPECIAL_BYTES[$urandom_range(0, 13)];
            else c.data[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 25));
         end
         r = $urandom_range(0, 9);
         c.count = (r < 7) ? 4'd8 : (r < 8) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
         r = $urandom_range(0, 9);
         c.base = (r == 0) ? '0 : (r == 1) ? BASE_MAX :
                  (r == 2) ? BASE_MAX - hdse_pkg::BASE_W'($urandom_range(0, 40))
                           : hdse_pkg::BASE_W'($urandom);
         c.first = (k == 0);
         // broken scans never see their range end
         c.last = (k == len - 1) && (kind < 92);
         push_chunk(c);
      end
   endtask

   // response receiver with its own stall pattern
   initial begin
      int pattern;
      int len;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_active = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_active      = 1'b0;
            hold_off_request = 1'b0;
         end else begin
            pattern = $urandom_range(0, 3);
            len     = $urandom_range(1, 40);
            repeat (len) begin
               case (pattern)
                  0:       rsp_ch.ready <= 1'b1;
                  1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                  default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // response checking and watchdog
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_response({rsp_ch.position, rsp_ch.found, rsp_ch.self_close,
                                    rsp_ch.all_ascii});
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int                          k;
      int                          phase;
      logic [hdse_pkg::MODE_W-1:0] m;
      logic [63:0]                 d;
      tracker          = new();
      work_items       = 0;
      burst_left       = 0;
      bursty           = 1'b1;
      hold_off_request = 1'b0;
      hold_active      = 1'b0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.data_bytes  <= '0;
      req_ch.byte_count  <= '0;
      req_ch.first_item  <= 1'b0;
      req_ch.last_item   <= 1'b0;
      req_ch.base_offset <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: text mode corner cases
      write_mode(hdse_pkg::MODE_TEXT);
      push_chunk(make_chunk(pack_text("<<<<<<<<"), 4'd8, 1'b0, 1'b1, '0));
      push_chunk(make_chunk(pack_text("ab&cd<ef"), 4'd8, 1'b1, 1'b1, '0));
      push_chunk(make_chunk(pack_text("ab\015cdefg"), 4'd8, 1'b1, 1'b1, 31'd100));
      d = pack_text("abcdefgh");
      d[15:8] = hdse_pkg::CH_NUL;
      push_chunk(make_chunk(d, 4'd8, 1'b1, 1'b1, 31'd200));
      // cursor runs past 31 bits, then an empty range end
      push_chunk(make_chunk(pack_text("abcdefgh"), 4'd8, 1'b1, 1'b0, BASE_MAX));
      push_chunk(make_chunk(pack_text("ijklmnop"), 4'd0, 1'b0, 1'b1, '0));
      push_chunk(make_chunk(pack_text("abcdefg&"), 4'd15, 1'b1, 1'b1, 31'd300));
      push_chunk(make_chunk(pack_text("abc<<<<<"), 4'd3, 1'b1, 1'b1, 31'd400));
      // restart in the middle of a scan, then bytes after the match
      push_chunk(make_chunk(pack_text("abcdefgh"), 4'd8, 1'b1, 1'b0, 31'd500));
      push_chunk(make_chunk(pack_text("xyz<abcd"), 4'd8, 1'b1, 1'b0, 31'd600));
      push_chunk(make_chunk(pack_text("<"), 4'd8, 1'b0, 1'b1, '0));

      // directed: one scan per remaining mode plus an unused one
      for (k = 1; k <= 10; k++) begin
         m = (k == 10) ? MODE_UNUSED_TOP : hdse_pkg::MODE_W'(k);
         case (m)
            hdse_pkg::MODE_TAGNAME:  d = pack_text("div-x y>");
            hdse_pkg::MODE_DQ_AMP:   d = pack_text("ab'\"cd&e");
            hdse_pkg::MODE_SQ_AMP:   d = pack_text("ab\"&cd'e");
            hdse_pkg::MODE_DQ:       d = pack_text("a&'b\"cde");
            hdse_pkg::MODE_SQ:       d = pack_text("a&\"b'cde");
            hdse_pkg::MODE_ATTRS:    d = pack_text("a='>'/>x");
            hdse_pkg::MODE_UNQUOTED: d = pack_text("abc\tdefg");
            hdse_pkg::MODE_GT:       d = pack_text("a<b>cdef");
            hdse_pkg::MODE_ASCII: begin
               d = pack_text("abcdefgh");
               d[31:24] = hdse_pkg::CH_HIGH;
            end
            default:                 d = pack_text("<&\"'> \t\015");
         endcase
         write_mode(m);
         push_chunk(make_chunk(d, 4'd8, 1'b1, 1'b1, hdse_pkg::BASE_W'(k * 1000)));
      end

      // attrs: slash as the last byte, then mode changes with an open quote
      write_mode(hdse_pkg::MODE_ATTRS);
      push_chunk(make_chunk(pack_text("a b c d/"), 4'd8, 1'b1, 1'b1, 31'd20000));
      push_chunk(make_chunk(pack_text("x=\"a>b c"), 4'd8, 1'b1, 1'b0, 31'd21000));
      write_mode(hdse_pkg::MODE_TEXT);
      push_chunk(make_chunk(pack_text("abcdefgh"), 4'd8, 1'b0, 1'b0, '0));
      write_mode(hdse_pkg::MODE_ATTRS);
      push_chunk(make_chunk(pack_text(">\"/>zzzz"), 4'd8, 1'b0, 1'b1, '0));
      write_mode(hdse_pkg::MODE_ASCII);
      push_chunk(make_chunk(pack_text("plain tx"), 4'd8, 1'b1, 1'b1, 31'd22000));

      // back-pressure: receiver holds off while every transfer makes a response
      write_mode(hdse_pkg::MODE_TEXT);
      hold_off_request = 1'b1;
      wait (hold_active);
      bursty = 1'b0;
      repeat (40)
         push_chunk(make_chunk(pack_text("a<bcdefg"), 4'd8, 1'b1, 1'b1,
                               hdse_pkg::BASE_W'($urandom)));
      bursty = 1'b1;

      // random scans, one scan mode per phase
      phase = 0;
      while (work_items < ITEM_TARGET) begin
         m = (phase < 16) ? hdse_pkg::MODE_W'(phase) : hdse_pkg::MODE_W'($urandom_range(0, 15));
         write_mode(m);
         repeat ($urandom_range(3, 8)) run_scan();
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (tracker.error_count == 0 && tracker.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
design/hdse_pkg.sv
design/hdse_if.sv
design/hdse_lane.sv
design/hdse_merge.sv
design/html_delimiter_scan_engine.sv
design/hdse_checker.sv
test/html_delimiter_scan_engine_tb.sv
